>>> rtl/prfa_pkg.sv
`timescale 1ns / 1ps

package prfa_pkg;

   localparam int PAGE_W   = 52;
   localparam int COUNT_W  = 20;
   localparam int STATUS_W = 3;

   localparam logic [63:0] BASE_VADDR = 64'hFFFF_FE00_0000_0000;
   localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_FROM_TABLE   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FROM_BUMP    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREE_STORED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREE_DROPPED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_SPACE = 3'd4;

   // where the granted page of a result comes from
   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_READ = 2'd1;
   localparam logic [1:0] SRC_BUMP = 2'd2;

   typedef struct packed {
      logic                load;
      logic                scan_clear;
      logic                scan_rd;
      logic                take;
      logic                last_rd;
      logic                copy;
      logic                free_push;
      logic                bump_adv;
      logic                set_res;
      logic [STATUS_W-1:0] res_status;
      logic [1:0]          res_src;
      logic                emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_free;
      logic count_zero;
      logic table_full;
      logic rd_vld;
      logic hit;
      logic hit_empty;
      logic scan_more;
      logic bump_ok;
      logic out_free;
   } dp_stat_type;

endpackage

>>> rtl/page_range_first_fit_allocator.sv
`timescale 1ns / 1ps

// Page range allocator: first fit over a table of freed ranges, falling back to
// a bump pointer that starts at the top-of-space base page and reports
// out_of_space rather than wrapping. One request is handled at a time and each
// gives exactly one response. An allocate walks the freed-range table one slot
// per cycle through the single read port of the table memory; when the chosen
// range empties, the last entry is read and moved into its slot. A finished
// response sits in the output register while the next request is taken. Ranges
// are never merged.
module page_range_first_fit_allocator
   import prfa_pkg::*;
#(
   parameter int FREE_SLOTS = 512,
   parameter int PAGE_SHIFT = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [COUNT_W-1:0]  req_page_count,
   input  logic [PAGE_W-1:0]   req_free_start_page,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PAGE_W-1:0]   rsp_start_page,
   output logic [STATUS_W-1:0] rsp_status
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   prfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   prfa_datapath #(
      .FREE_SLOTS (FREE_SLOTS),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_command         (req_command),
      .req_page_count      (req_page_count),
      .req_free_start_page (req_free_start_page),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_start_page      (rsp_start_page),
      .rsp_status          (rsp_status),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule

>>> rtl/prfa_ctrl.sv
`timescale 1ns / 1ps

module prfa_ctrl
   import prfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_BUMP = 3'd3;
   localparam logic [2:0] S_LAST = 3'd4;
   localparam logic [2:0] S_COPY = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.is_free) begin
               cmd.set_res = 1'b1;
               cmd.res_src = SRC_ZERO;
               if (stat.count_zero || stat.table_full) begin
                  cmd.res_status = ST_FREE_DROPPED;
               end else begin
                  cmd.free_push  = 1'b1;
                  cmd.res_status = ST_FREE_STORED;
               end
               state_in = S_DONE;
            end else if (stat.count_zero) begin
               cmd.set_res    = 1'b1;
               cmd.res_src    = SRC_ZERO;
               cmd.res_status = ST_OUT_OF_SPACE;
               state_in       = S_DONE;
            end else begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            // compare of the slot read last cycle overlaps the read of the next
            if (stat.rd_vld && stat.hit) begin
               cmd.take       = 1'b1;
               cmd.set_res    = 1'b1;
               cmd.res_src    = SRC_READ;
               cmd.res_status = ST_FROM_TABLE;
               state_in       = stat.hit_empty ? S_LAST : S_DONE;
            end else if (stat.scan_more) begin
               cmd.scan_rd = 1'b1;
            end else begin
               state_in = S_BUMP;
            end
         end
         S_BUMP: begin
            cmd.set_res = 1'b1;
            if (stat.bump_ok) begin
               cmd.bump_adv   = 1'b1;
               cmd.res_src    = SRC_BUMP;
               cmd.res_status = ST_FROM_BUMP;
            end else begin
               cmd.res_src    = SRC_ZERO;
               cmd.res_status = ST_OUT_OF_SPACE;
            end
            state_in = S_DONE;
         end
         S_LAST: begin
            cmd.last_rd = 1'b1;
            state_in    = S_COPY;
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/prfa_datapath.sv
`timescale 1ns / 1ps

module prfa_datapath
   import prfa_pkg::*;
#(
   parameter int FREE_SLOTS = 512,
   parameter int PAGE_SHIFT = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_command,
   input  logic [COUNT_W-1:0]  req_page_count,
   input  logic [PAGE_W-1:0]   req_free_start_page,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PAGE_W-1:0]   rsp_start_page,
   output logic [STATUS_W-1:0] rsp_status,
   input  ctl_cmd_type         cmd,
   output dp_stat_type         stat
);

   localparam int IDX_W   = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int CNT_W   = $clog2(FREE_SLOTS + 1);
   localparam int ENTRY_W = PAGE_W + COUNT_W;
   localparam logic [63:0] BASE_SHIFTED = BASE_VADDR >> PAGE_SHIFT;
   localparam logic [PAGE_W-1:0] BUMP_RESET = BASE_SHIFTED[PAGE_W-1:0];
   localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(FREE_SLOTS);

   logic [ENTRY_W-1:0] mem [FREE_SLOTS];

   logic                cmd_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [PAGE_W-1:0]   start_ff;
   logic [CNT_W-1:0]    used_ff;
   logic [CNT_W-1:0]    used_in;
   logic [PAGE_W-1:0]   bump_ff;
   logic [CNT_W-1:0]    scan_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_vld_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [PAGE_W-1:0]   res_page_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic                rsp_valid_ff;
   logic [PAGE_W-1:0]   rsp_page_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [PAGE_W-1:0]  rd_start;
   logic [COUNT_W-1:0] rd_len;
   logic [CNT_W-1:0]   last_cnt;
   logic [IDX_W-1:0]   rd_addr;
   logic               rd_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;
   logic [PAGE_W:0]    bump_end;
   logic [PAGE_W-1:0]  res_page_in;

   assign rd_start = rd_data_ff[ENTRY_W-1:COUNT_W];
   assign rd_len   = rd_data_ff[COUNT_W-1:0];
   assign last_cnt = used_ff - CNT_W'(1);
   assign bump_end = {1'b0, bump_ff} + {{(PAGE_W + 1 - COUNT_W){1'b0}}, count_ff};

   assign stat.is_free    = (cmd_ff == CMD_FREE);
   assign stat.count_zero = (count_ff == '0);
   assign stat.table_full = (used_ff == SLOTS_FULL);
   assign stat.rd_vld     = rd_vld_ff;
   assign stat.hit        = (rd_len >= count_ff);
   assign stat.hit_empty  = (rd_len == count_ff);
   assign stat.scan_more  = (scan_ff < used_ff);
   assign stat.bump_ok    = (bump_end <= {1'b0, PAGE_MAX});
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rd_en   = cmd.scan_rd || cmd.last_rd;
      rd_addr = cmd.last_rd ? last_cnt[IDX_W-1:0] : scan_ff[IDX_W-1:0];
      wr_en   = cmd.free_push || cmd.take || cmd.copy;
      wr_addr = rd_idx_ff;
      wr_data = {rd_start + {{(PAGE_W - COUNT_W){1'b0}}, count_ff}, rd_len - count_ff};
      if (cmd.free_push) begin
         wr_addr = used_ff[IDX_W-1:0];
         wr_data = {start_ff, count_ff};
      end else if (cmd.copy) begin
         // the last entry fills the slot that ran empty
         wr_addr = hit_idx_ff;
         wr_data = rd_data_ff;
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.free_push) begin
         used_in = used_ff + CNT_W'(1);
      end else if (cmd.last_rd) begin
         used_in = last_cnt;
      end
   end

   always_comb begin
      case (cmd.res_src)
         SRC_READ: res_page_in = rd_start;
         SRC_BUMP: res_page_in = bump_ff;
         default:  res_page_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_command;
         count_ff <= req_page_count;
         start_ff <= req_free_start_page;
      end
      if (cmd.take) begin
         hit_idx_ff <= rd_idx_ff;
      end
      if (cmd.set_res) begin
         res_page_ff   <= res_page_in;
         res_status_ff <= cmd.res_status;
      end
      if (cmd.emit) begin
         rsp_page_ff   <= res_page_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         bump_ff      <= BUMP_RESET;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         rd_vld_ff <= cmd.scan_rd;
         if (cmd.scan_clear) begin
            scan_ff <= '0;
         end else if (cmd.scan_rd) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
         if (cmd.bump_adv) begin
            bump_ff <= bump_end[PAGE_W-1:0];
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_start_page = rsp_page_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
